[sv/lh_pkg.sv]
// shared constants for the luma histogram: opcodes, luma coefficients, stream widths
// no dependencies; used by luma_histogram_top and lh_checker
package lh_pkg;

  // opcodes carried on the slave tuser; the unused code behaves as a read
  localparam logic [1:0] OP_ACCUM = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // bt.601 weights in unsigned 0.16 fixed point (0.299, 0.587, 0.114)
  localparam int unsigned COEF_W    = 16;
  localparam logic [COEF_W-1:0] COEF_C0 = 16'd19595;
  localparam logic [COEF_W-1:0] COEF_C1 = 16'd38470;
  localparam logic [COEF_W-1:0] COEF_C2 = 16'd7471;
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned LUMA_W    = 8;
  localparam int unsigned PROD_W    = COEF_W + CHAN_W;
  localparam int unsigned NUM_BINS  = 256;
  localparam int unsigned CNT_OUT_W = 32;

  // stream widths
  localparam int unsigned S_TDATA_W = 32;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 1;

endpackage

[sv/luma_histogram_top.sv]
// luma histogram top level: luma computation, 256-bin count memory and stream ports
// depends on lh_pkg
//
// Each slave item is an opcode on tuser and a pixel or bin number on tdata. An accumulate
// item computes bt.601 luma, (19595*c0 + 38470*c1 + 7471*c2) >> 16, and adds one to that
// luma's bin, holding at the largest COUNT_BITS-bit value; a read item returns the
// selected bin; a clear item zeroes it (opcode 3 acts as a read). Every item gives exactly
// one master item: the bin number, the low 32 bits of its count after the operation and
// a flag set when the count sits at its maximum. An item reaches the result register
// through the read-modify-write of the single count memory (products at the accepting
// edge, then sum and memory read, then update and write back); one item is in flight at
// a time and the slave side reopens in the cycle after the update, so the block takes no
// new item until the last is written back, and the update waits while the master
// side stalls a finished result that has not yet left the output register.
// The counts are zero after reset without a clearing pass: a valid bit per bin, cleared
// by reset, makes a bin read as zero until it is first written.
module luma_histogram_top #(
  parameter int unsigned COUNT_BITS = 32  // width of each bin count, 16 to 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave side
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // first_channel, second_channel, third_channel, bin_select (lowest first)
  input  logic [lh_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  // opcode
  input  logic [lh_pkg::S_TUSER_W-1:0]  s_axis_tuser_i,
  // master side
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // bin_index, bin_count (lowest first)
  output logic [lh_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  // saturated
  output logic [lh_pkg::M_TUSER_W-1:0]  m_axis_tuser_o
);
  import lh_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  // one-hot sequencer: idle, sum and memory read, update and write back
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SUM  = 3'b010,
    ST_RMW  = 3'b100
  } lh_state_e;

  lh_state_e state_q, state_d;

  // item held while in flight
  logic [1:0]        op_q;
  logic [LUMA_W-1:0] sel_q;
  logic [PROD_W-1:0] prod0_q, prod1_q, prod2_q;
  logic [LUMA_W-1:0] idx_q, idx_d;

  // count memory and its per-bin valid bits
  logic [COUNT_BITS-1:0] mem_q [NUM_BINS];
  logic [COUNT_BITS-1:0] rd_data_q;
  logic                  rd_valid_q;
  logic [NUM_BINS-1:0]   valid_q;

  // update path
  logic [COUNT_BITS-1:0] old_cnt, new_cnt;
  logic [CNT_OUT_W-1:0]  cnt_out;
  logic [PROD_W:0]       luma_sum;
  logic                  out_free;
  logic                  s_accept;
  logic                  finish;
  logic                  mem_we;

  // output register
  logic                  m_valid_q;
  logic [M_TDATA_W-1:0]  m_data_q;
  logic [M_TUSER_W-1:0]  m_user_q;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign finish   = (state_q == ST_RMW) && out_free;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid_i) state_d = ST_SUM;
      ST_SUM:  state_d = ST_RMW;
      ST_RMW:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // stage one: capture item and form the weighted products
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q    <= s_axis_tuser_i;
      sel_q   <= s_axis_tdata_i[31:24];
      prod0_q <= COEF_C0 * s_axis_tdata_i[7:0];
      prod1_q <= COEF_C1 * s_axis_tdata_i[15:8];
      prod2_q <= COEF_C2 * s_axis_tdata_i[23:16];
    end
  end

  // stage two: sum the products (weights add to one, so luma fits 8 bits) and pick the bin
  assign luma_sum = {1'b0, prod0_q} + {1'b0, prod1_q} + {1'b0, prod2_q};
  assign idx_d    = (op_q == OP_ACCUM) ? luma_sum[FRAC_BITS +: LUMA_W] : sel_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      idx_q      <= idx_d;
      rd_data_q  <= mem_q[idx_d];
      rd_valid_q <= valid_q[idx_d];
    end
  end

  // stage three: modify; one item in flight, so no overlap on the same bin
  assign old_cnt = rd_valid_q ? rd_data_q : '0;

  always_comb begin
    case (op_q)
      OP_ACCUM: new_cnt = (old_cnt == CountMax) ? old_cnt : old_cnt + COUNT_BITS'(1);
      OP_CLEAR: new_cnt = '0;
      default:  new_cnt = old_cnt;
    endcase
  end

  assign mem_we = finish && ((op_q == OP_ACCUM) || (op_q == OP_CLEAR));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= new_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (mem_we) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // wide counts show their low 32 bits, narrow ones are zero-extended
  if (COUNT_BITS >= CNT_OUT_W) begin : g_cnt_trunc
    assign cnt_out = new_cnt[CNT_OUT_W-1:0];
  end else begin : g_cnt_ext
    assign cnt_out = {{(CNT_OUT_W - COUNT_BITS){1'b0}}, new_cnt};
  end

  // output register parts the master side from the update stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      m_data_q <= {cnt_out, idx_q};
      m_user_q <= (new_cnt == CountMax);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

[sv/lh_checker.sv]
// port-level checks for the luma histogram, bound to luma_histogram_top
// depends on lh_pkg
module lh_checker #(
  parameter int unsigned COUNT_BITS = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic [lh_pkg::S_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [lh_pkg::S_TUSER_W-1:0]  s_axis_tuser_i,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [lh_pkg::M_TDATA_W-1:0]  m_axis_tdata_o,
  input logic [lh_pkg::M_TUSER_W-1:0]  m_axis_tuser_o
);
  import lh_pkg::*;

  localparam logic [CNT_OUT_W-1:0] SatLow = (COUNT_BITS >= CNT_OUT_W) ? '1 :
    CNT_OUT_W'((64'd1 << COUNT_BITS) - 64'd1);

  logic s_accept;
  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;

  // one item in flight: the slave side stays closed while it is summed and updated
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready_o ##1 !s_axis_tready_o)
    else $error("slave side reopened before the item was updated");

  // a saturated flag only comes with a count at its maximum
  a_sat_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> (m_axis_tdata_o[39:8] == SatLow))
    else $error("saturated flag with a count below maximum");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("stalled result changed");

endmodule

bind luma_histogram_top lh_checker #(.COUNT_BITS(COUNT_BITS)) u_lh_checker (.*);
